FILE: rtl/kpbc_pkg.sv
// Package for the key press balance checker: verdict codes, widths and cell control.
package kpbc_pkg;

	// Largest number of checked steps in one sequence.
	localparam int MaxStepsDefault = 16;

	// Fixed field widths.
	localparam int KeyW     = 16;
	localparam int ValueW   = 8;
	localparam int VerdictW = 3;
	localparam int SeenW    = 5;

	// Verdict codes, also used as the first-error code (OK means no error yet).
	typedef enum logic [VerdictW-1:0] {
		VERDICT_OK           = 3'd0,
		VERDICT_BAD_STEP     = 3'd1,
		VERDICT_PRESSED_TWICE = 3'd2,
		VERDICT_RELEASE_UNHELD = 3'd3,
		VERDICT_LEFT_HELD    = 3'd4,
		VERDICT_TOO_MANY     = 3'd5
	} verdict_t;

	// Per-step command broadcast to every cell of the held-key chain.
	typedef struct packed {
		logic            append;  // store keycode in the first free cell
		logic            shift;   // remove the matching key by shifting cells down
		logic [KeyW-1:0] keycode; // keycode of the current step
	} cell_ctrl_t;

endpackage

FILE: rtl/kpbc_cell.sv
// One held-key cell: stores a keycode, compares it, and shifts down from its neighbor.
module kpbc_cell import kpbc_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,      // command of the current step
	input  logic [CNT_W-1:0] count,     // number of occupied cells
	input  logic [KeyW-1:0]  next_key,  // key held by the cell above
	input  logic             hit_in,    // a cell below matched the keycode
	output logic [KeyW-1:0]  key,       // key held by this cell
	output logic             hit_out    // this cell or one below matched
);

	localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

	logic [KeyW-1:0] key_q;
	logic            occupied;
	logic            match;

	// A cell takes part only while it lies below the fill count.
	assign occupied = MyIdx < count;
	assign match    = occupied && (key_q == ctrl.keycode);
	assign hit_out  = hit_in || match;
	assign key      = key_q;

	// Append writes the first free cell; a release closes the gap from above.
	always_ff @(posedge clk) begin
		if (ctrl.append && (MyIdx == count)) begin
			key_q <= ctrl.keycode;
		end else if (ctrl.shift && (hit_in || match)) begin
			key_q <= next_key;
		end
	end

endmodule

FILE: rtl/key_press_balance_checker.sv
// Top level of the key press balance checker: step control, held-key chain, verdict output.
// A request marked last gives its verdict on the output in the cycle after it is taken.
// One step per cycle unless stalled; the held-key chain compares and updates all cells at once.
// While a verdict waits to be taken, the input stalls until the output side is ready.
// Reset (arst_n low, asynchronous) empties the held set and clears the step count,
// the first error and the output valid flag; stored keycodes need no reset.
module key_press_balance_checker import kpbc_pkg::*; #(
	parameter int MAX_STEPS = MaxStepsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // keycode [15:0], press_value [23:16]
	input  logic        s_tlast,  // last_step
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // verdict [2:0], steps_seen [7:3]
);

	localparam int CNT_W  = $clog2(MAX_STEPS + 1);
	localparam int STEP_W = $clog2(MAX_STEPS + 2);
	localparam logic [CNT_W-1:0]  MaxCnt  = CNT_W'(MAX_STEPS);
	localparam logic [STEP_W-1:0] MaxStep = STEP_W'(MAX_STEPS);

	logic [CNT_W-1:0]  held_count_q;
	logic [STEP_W-1:0] step_count_q;
	verdict_t          first_error_q;
	logic              out_valid_q;
	verdict_t          out_verdict_q;
	logic [SeenW-1:0]  out_seen_q;

	logic              take;
	logic [KeyW-1:0]   keycode;
	logic [ValueW-1:0] press_value;
	logic [STEP_W-1:0] step_next;
	logic              check;
	logic              bad;
	logic              found;
	logic              is_press;
	cell_ctrl_t        ctrl;
	logic [CNT_W-1:0]  count_next;
	verdict_t          error_next;
	verdict_t          verdict;

	logic [KeyW-1:0]   cell_key [MAX_STEPS];
	logic [MAX_STEPS:0] hit;

	assign keycode     = s_tdata[KeyW-1:0];
	assign press_value = s_tdata[KeyW+ValueW-1:KeyW];
	assign s_tready    = !out_valid_q || m_tready;
	assign take        = s_tvalid && s_tready;

	// Step counting saturates one past the limit; only steps within it are checked.
	assign step_next = (step_count_q <= MaxStep) ? step_count_q + 1'b1 : step_count_q;
	assign check     = (step_next <= MaxStep) && (first_error_q == VERDICT_OK);
	assign bad       = (press_value > ValueW'(1)) || (keycode == '0);
	assign is_press  = press_value[0];
	assign found     = hit[MAX_STEPS];

	// Decide the held-set update and any new error for this step.
	always_comb begin
		ctrl.keycode = keycode;
		ctrl.append  = 1'b0;
		ctrl.shift   = 1'b0;
		count_next   = held_count_q;
		error_next   = first_error_q;
		if (take && check) begin
			if (bad) begin
				error_next = VERDICT_BAD_STEP;
			end else if (is_press) begin
				if (found) begin
					error_next = VERDICT_PRESSED_TWICE;
				end else if (held_count_q < MaxCnt) begin
					ctrl.append = 1'b1;
					count_next  = held_count_q + 1'b1;
				end
			end else begin
				if (!found) begin
					error_next = VERDICT_RELEASE_UNHELD;
				end else begin
					ctrl.shift = 1'b1;
					count_next = held_count_q - 1'b1;
				end
			end
		end
	end

	// Verdict of a sequence ending with this step; too many steps wins over all.
	always_comb begin
		if (step_next > MaxStep) begin
			verdict = VERDICT_TOO_MANY;
		end else if (error_next != VERDICT_OK) begin
			verdict = error_next;
		end else if (count_next != '0) begin
			verdict = VERDICT_LEFT_HELD;
		end else begin
			verdict = VERDICT_OK;
		end
	end

	// Chain of held-key cells; the match ripples up to find the first hit.
	assign hit[0] = 1'b0;
	for (genvar i = 0; i < MAX_STEPS; i++) begin : g_cell
		logic [KeyW-1:0] above;
		if (i == MAX_STEPS - 1) begin : g_top
			assign above = cell_key[i];
		end else begin : g_mid
			assign above = cell_key[i+1];
		end
		kpbc_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (held_count_q),
			.next_key (above),
			.hit_in   (hit[i]),
			.key      (cell_key[i]),
			.hit_out  (hit[i+1])
		);
	end

	// Sequence state; a last step returns everything to the empty sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q  <= '0;
			step_count_q  <= '0;
			first_error_q <= VERDICT_OK;
		end else if (take) begin
			if (s_tlast) begin
				held_count_q  <= '0;
				step_count_q  <= '0;
				first_error_q <= VERDICT_OK;
			end else begin
				held_count_q  <= count_next;
				step_count_q  <= step_next;
				first_error_q <= error_next;
			end
		end
	end

	// Output register holding one verdict until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && s_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s_tlast) begin
			out_verdict_q <= verdict;
			out_seen_q    <= SeenW'(step_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_seen_q, out_verdict_q};

endmodule

FILE: dv/tb_key_press_balance_checker.sv
// Self-checking testbench for the key press balance checker.
`timescale 1ns / 100ps

module tb_key_press_balance_checker;
	import kpbc_pkg::*;

	localparam int MaxSteps   = MaxStepsDefault;
	localparam int RandomGoal = 1000;
	localparam int CycleLimit = 300000;

	// One step request with an optional verdict typed in by hand.
	typedef struct {
		logic [KeyW-1:0]   key;
		logic [ValueW-1:0] value;
		logic              last;
		bit                typed;
		verdict_t          verdict;
		logic [SeenW-1:0]  seen;
	} step_row_t;

	// One verdict request as it should leave the block.
	typedef struct {
		verdict_t         verdict;
		logic [SeenW-1:0] seen;
	} verdict_item_t;

	// Kinds of step the random generator can produce.
	typedef enum int {
		KIND_PRESS,
		KIND_RELEASE,
		KIND_PRESS_AGAIN,
		KIND_RELEASE_FREE,
		KIND_BAD_VALUE,
		KIND_ZERO_KEY
	} step_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // keycode [15:0], press_value [23:16]
	logic        s_tlast;  // last_step
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // verdict [2:0], steps_seen [7:3]

	// Predicted state of the held-key set.
	logic [KeyW-1:0] bal_keys[MaxSteps];
	int              bal_count;
	int              bal_steps;
	verdict_t        bal_error;

	verdict_item_t pending_verdicts[$];
	step_row_t     directed_rows[$];
	int            mismatches;
	int            sent_steps;
	int            sent_runs;
	int            checked_verdicts;
	int            verdict_hits[6];
	int            cycle_count;

	key_press_balance_checker #(
		.MAX_STEPS(MaxSteps)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Timeout after %0d cycles with %0d verdicts outstanding.",
				cycle_count, pending_verdicts.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("Mismatch at cycle %0d on %s: got %0d, expected %0d.",
			cycle_count, what, got, want);
	endtask

	// Advances the predicted held set by one step and gives the verdict on a last step.
	function automatic void balance_step(input logic [KeyW-1:0] key,
			input logic [ValueW-1:0] value, input logic last,
			output bit has_verdict, output verdict_item_t result);
		int at;
		int j;
		has_verdict = 1'b0;
		result.verdict = VERDICT_OK;
		result.seen = '0;
		if (bal_steps <= MaxSteps) begin
			bal_steps++;
		end
		// Steps past the limit or after an error leave the set alone.
		if (bal_steps <= MaxSteps && bal_error == VERDICT_OK) begin
			if (value > 1 || key == '0) begin
				bal_error = VERDICT_BAD_STEP;
			end else begin
				at = bal_count;
				for (j = 0; j < bal_count; j++) begin
					if (bal_keys[j] == key) begin
						at = j;
						break;
					end
				end
				if (value == 1) begin
					if (at != bal_count) begin
						bal_error = VERDICT_PRESSED_TWICE;
					end else if (bal_count < MaxSteps) begin
						bal_keys[bal_count] = key;
						bal_count++;
					end
				end else if (at == bal_count) begin
					bal_error = VERDICT_RELEASE_UNHELD;
				end else begin
					bal_count--;
					bal_keys[at] = bal_keys[bal_count];
				end
			end
		end
		// The last step reports and clears the run.
		if (last) begin
			has_verdict = 1'b1;
			if (bal_steps > MaxSteps) begin
				result.verdict = VERDICT_TOO_MANY;
			end else if (bal_error != VERDICT_OK) begin
				result.verdict = bal_error;
			end else if (bal_count != 0) begin
				result.verdict = VERDICT_LEFT_HELD;
			end else begin
				result.verdict = VERDICT_OK;
			end
			result.seen = bal_steps[SeenW-1:0];
			bal_count = 0;
			bal_steps = 0;
			bal_error = VERDICT_OK;
		end
	endfunction

	task automatic add_row(input logic [KeyW-1:0] key, input logic [ValueW-1:0] value,
			input logic last, input bit typed, input verdict_t verdict,
			input logic [SeenW-1:0] seen);
		step_row_t row;
		row.key = key;
		row.value = value;
		row.last = last;
		row.typed = typed;
		row.verdict = verdict;
		row.seen = seen;
		directed_rows.push_back(row);
	endtask

	// Sends one step request after a random or no gap and records what it should give.
	task automatic send_step(input step_row_t row);
		int gap;
		bit has_verdict;
		verdict_item_t predicted;
		verdict_item_t typed_item;
		gap = (((sent_steps / 100) % 3) == 2) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {row.value, row.key};
		s_tlast <= row.last;
		do @(posedge clk); while (s_tready !== 1'b1);
		balance_step(row.key, row.value, row.last, has_verdict, predicted);
		if (row.typed) begin
			typed_item.verdict = row.verdict;
			typed_item.seen = row.seen;
			pending_verdicts.push_back(typed_item);
		end else if (has_verdict) begin
			pending_verdicts.push_back(predicted);
		end
		sent_steps++;
		if (row.last) begin
			sent_runs++;
		end
	endtask

	function automatic bit key_in(input logic [KeyW-1:0] key, input logic [KeyW-1:0] keys[$]);
		foreach (keys[i]) begin
			if (keys[i] == key) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Nonzero key that is not in the given set; often from a small pool to force reuse.
	function automatic logic [KeyW-1:0] fresh_key(input logic [KeyW-1:0] keys[$]);
		logic [KeyW-1:0] key;
		do begin
			key = ($urandom_range(0, 1) == 0) ? KeyW'($urandom_range(1, 40))
				: KeyW'($urandom_range(1, 65535));
		end while (key_in(key, keys));
		return key;
	endfunction

	// One random run: mostly balanced press/release patterns, some with injected faults.
	task automatic run_random_steps();
		int len;
		int i;
		int pick;
		bit noisy;
		step_kind_t kind;
		step_row_t row;
		logic [KeyW-1:0] gen_held[$];
		noisy = ($urandom_range(0, 9) < 3);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxSteps + 1, MaxSteps + 4)
			: $urandom_range(1, MaxSteps);
		if (!noisy && (len % 2) == 1 && len < MaxSteps && $urandom_range(0, 1) == 1) begin
			len++;
		end
		for (i = 0; i < len; i++) begin
			if (noisy) begin
				kind = step_kind_t'($urandom_range(0, 5));
			end else if (gen_held.size() == 0) begin
				kind = KIND_PRESS;
			end else if (gen_held.size() >= len - i) begin
				kind = KIND_RELEASE;
			end else begin
				kind = ($urandom_range(0, 1) == 0) ? KIND_PRESS : KIND_RELEASE;
			end
			if (gen_held.size() == 0 && (kind == KIND_RELEASE || kind == KIND_PRESS_AGAIN)) begin
				kind = KIND_PRESS;
			end
			row.typed = 1'b0;
			row.verdict = VERDICT_OK;
			row.seen = '0;
			row.last = (i == len - 1);
			case (kind)
				KIND_PRESS: begin
					row.key = fresh_key(gen_held);
					row.value = 8'd1;
					gen_held.push_back(row.key);
				end
				KIND_RELEASE: begin
					pick = $urandom_range(0, gen_held.size() - 1);
					row.key = gen_held[pick];
					row.value = 8'd0;
					gen_held.delete(pick);
				end
				KIND_PRESS_AGAIN: begin
					row.key = gen_held[$urandom_range(0, gen_held.size() - 1)];
					row.value = 8'd1;
				end
				KIND_RELEASE_FREE: begin
					row.key = fresh_key(gen_held);
					row.value = 8'd0;
				end
				KIND_BAD_VALUE: begin
					row.key = KeyW'($urandom_range(0, 65535));
					row.value = ValueW'($urandom_range(2, 255));
				end
				default: begin
					row.key = '0;
					row.value = ValueW'($urandom_range(0, 1));
				end
			endcase
			send_step(row);
		end
	endtask

	// Result side: random stalls, then each accepted verdict is checked in order.
	initial begin
		int stall;
		verdict_item_t want;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = (((checked_verdicts / 80) % 3) == 1) ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected verdict", int'(m_tdata), 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[VerdictW-1:0] !== want.verdict) begin
					report_mismatch("verdict", int'(m_tdata[VerdictW-1:0]),
						int'(want.verdict));
				end
				if (m_tdata[VerdictW+SeenW-1:VerdictW] !== want.seen) begin
					report_mismatch("steps_seen", int'(m_tdata[VerdictW+SeenW-1:VerdictW]),
						int'(want.seen));
				end
				verdict_hits[int'(want.verdict)]++;
				checked_verdicts++;
			end
		end
	end

	// Main stimulus: reset, directed rows, random runs, then drain.
	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		bal_count = 0;
		bal_steps = 0;
		bal_error = VERDICT_OK;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero keycode, then the largest keycode with the largest press value.
		add_row(16'h0000, 8'd1, 1'b1, 1'b1, VERDICT_BAD_STEP, 5'd1);
		add_row(16'hFFFF, 8'hFF, 1'b1, 1'b1, VERDICT_BAD_STEP, 5'd1);
		// Balanced press and release of the largest keycode.
		add_row(16'hFFFF, 8'd1, 1'b0, 1'b0, VERDICT_OK, '0);
		add_row(16'hFFFF, 8'd0, 1'b1, 1'b1, VERDICT_OK, 5'd2);
		// Release with nothing held.
		add_row(16'h0001, 8'd0, 1'b1, 1'b1, VERDICT_RELEASE_UNHELD, 5'd1);
		// The same key pressed twice.
		add_row(16'h8000, 8'd1, 1'b0, 1'b0, VERDICT_OK, '0);
		add_row(16'h8000, 8'd1, 1'b1, 1'b1, VERDICT_PRESSED_TWICE, 5'd2);
		// A key still held at the last step.
		add_row(16'h1234, 8'd1, 1'b1, 1'b1, VERDICT_LEFT_HELD, 5'd1);
		// Fill the set, then one step past the limit; the bad step there is not checked.
		for (int k = 1; k <= MaxSteps; k++) begin
			add_row(KeyW'(k), 8'd1, 1'b0, 1'b0, VERDICT_OK, '0);
		end
		add_row(16'h0000, 8'hFF, 1'b1, 1'b1, VERDICT_TOO_MANY, 5'(MaxSteps + 1));
		foreach (directed_rows[i]) begin
			send_step(directed_rows[i]);
		end

		while (sent_steps < directed_rows.size() + RandomGoal) begin
			run_random_steps();
		end
		s_tvalid <= 1'b0;

		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Run covered %0d steps in %0d sequences and checked %0d verdicts.",
			sent_steps, sent_runs, checked_verdicts);
		$display("Verdicts: ok %0d, bad step %0d, pressed twice %0d, release unheld %0d, %s",
			verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
			$sformatf("left held %0d, too many %0d.", verdict_hits[4], verdict_hits[5]));
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
